[rtl/core/hkpo_pkg.sv]
// ----------------------------------------------------------------------------
// hkpo_pkg
// Types and codes shared by the hash keyed pool and its cells.
// ----------------------------------------------------------------------------
package hkpo_pkg;

    localparam int HASH_W = 256;
    localparam int WORD_W = 64;
    localparam int CNT_W  = 5;
    localparam int IN_W   = 648;
    localparam int OUT_W  = 336;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_CONTAINS = 2'd1,
        OP_CHILD    = 2'd2,
        OP_REMOVE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DUP      = 3'd1,
        ST_FOUND    = 3'd2,
        ST_NONE     = 3'd3,
        ST_REMOVED  = 3'd4
    } status_t;

    typedef struct packed {
        logic [HASH_W-1:0] key;
        logic [HASH_W-1:0] parent;
        logic [WORD_W-1:0] height;
        logic [WORD_W-1:0] tip;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic              free;
        logic              old_ok;
        logic [WORD_W-1:0] old_age;
        logic              ch_ok;
        logic [WORD_W-1:0] ch_age;
        logic [HASH_W-1:0] ch_key;
        logic [WORD_W-1:0] ch_tip;
        logic [CNT_W-1:0]  cnt;
    } acc_t;

    typedef struct packed {
        logic wr;
        logic clr;
    } cmd_t;

endpackage

[rtl/core/hash_keyed_pool_oldest_eviction.sv]
// ----------------------------------------------------------------------------
// hash_keyed_pool_oldest_eviction
// Fully associative pool keyed by a 256-bit hash with oldest-first eviction.
// ----------------------------------------------------------------------------
// Sequence: the accepted input beat is registered, then the scan walks the cell chain one slot per
// cycle; the done state then forms the result, applies the update and offers the output beat.
// A new beat is accepted only in the idle state, once the previous result has been formed; a
// stalled output beat holds the last state.
// Reset: asynchronous, active low; clears all slot valid bits and the age counter.
module hash_keyed_pool_oldest_eviction #(
    parameter int POOL_DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // op, key_word0..3, parent_word0..3, entry_height, seen_tip_height, zero pad
    input  logic [hkpo_pkg::IN_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status, evicted, match_word0..3, match_seen_tip, occupancy, zero pad
    output logic [hkpo_pkg::OUT_W-1:0] m_tdata
);
    import hkpo_pkg::*;

    localparam int IW = (POOL_DEPTH > 2) ? $clog2(POOL_DEPTH) : 1;
    localparam logic [IW-1:0] LAST = IW'(POOL_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     ctr_reg, ctr_next;
    op_t               op_reg;
    req_t              req_reg;
    logic [WORD_W-1:0] age_reg, age_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_reg, out_next;
    cmd_t              cmd;
    logic [IW-1:0]     cmd_idx;

    acc_t          acc_chain [POOL_DEPTH+1];
    logic [IW-1:0] hit_chain [POOL_DEPTH+1];
    logic [IW-1:0] free_chain [POOL_DEPTH+1];
    logic [IW-1:0] old_chain [POOL_DEPTH+1];

    assign acc_chain[0]  = '0;
    assign hit_chain[0]  = '0;
    assign free_chain[0] = '0;
    assign old_chain[0]  = '0;

    for (genvar i = 0; i < POOL_DEPTH; i++)
    begin : g_cell
        hkpo_cell #(
            .IW      (IW),
            .CELL_ID (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .req          (req_reg),
            .age          (age_reg),
            .cmd          (cmd),
            .cmd_idx      (cmd_idx),
            .acc_in       (acc_chain[i]),
            .hit_idx_in   (hit_chain[i]),
            .free_idx_in  (free_chain[i]),
            .old_idx_in   (old_chain[i]),
            .acc_out      (acc_chain[i+1]),
            .hit_idx_out  (hit_chain[i+1]),
            .free_idx_out (free_chain[i+1]),
            .old_idx_out  (old_chain[i+1])
        );
    end

    acc_t              t;
    status_t           status;
    logic              evicted;
    logic [HASH_W-1:0] match_key;
    logic [WORD_W-1:0] match_tip;
    logic [CNT_W-1:0]  occ;
    logic              fire;

    assign t        = acc_chain[POOL_DEPTH];
    assign s_tready = (state_reg == S_IDLE);
    assign fire     = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        status    = ST_NONE;
        evicted   = 1'b0;
        match_key = '0;
        match_tip = '0;
        occ       = t.cnt;
        cmd       = '0;
        cmd_idx   = '0;
        age_next  = age_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (t.hit)
                begin
                    status = ST_DUP;
                end
                else
                begin
                    status   = ST_INSERTED;
                    cmd.wr   = fire;
                    cmd_idx  = t.free ? free_chain[POOL_DEPTH] : old_chain[POOL_DEPTH];
                    evicted  = !t.free;
                    occ      = t.cnt + CNT_W'(t.free);
                    age_next = fire ? age_reg + 64'd1 : age_reg;
                end
            end
            OP_CONTAINS:
            begin
                status = t.hit ? ST_FOUND : ST_NONE;
            end
            OP_CHILD:
            begin
                if (t.ch_ok)
                begin
                    status    = ST_FOUND;
                    match_key = t.ch_key;
                    match_tip = t.ch_tip;
                end
            end
            OP_REMOVE:
            begin
                if (t.hit)
                begin
                    status  = ST_REMOVED;
                    cmd.clr = fire;
                    cmd_idx = hit_chain[POOL_DEPTH];
                    occ     = t.cnt - CNT_W'(1);
                end
            end
            default:
            begin
                status = ST_NONE;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ctr_next       = ctr_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                ctr_next = '0;
                if (s_tvalid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctr_next = ctr_reg + IW'(1);
                if (ctr_reg == LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    out_next       = {7'd0, occ, match_tip, match_key, evicted, status};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctr_reg       <= '0;
            age_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            age_reg       <= age_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (s_tvalid && s_tready)
        begin
            op_reg      <= op_t'(s_tdata[1:0]);
            req_reg.key    <= s_tdata[257:2];
            req_reg.parent <= s_tdata[513:258];
            req_reg.height <= s_tdata[577:514];
            req_reg.tip    <= s_tdata[641:578];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

[rtl/core/hkpo_cell.sv]
// ----------------------------------------------------------------------------
// hkpo_cell
// One pool slot; folds its entry into the scan beat handed down the chain.
// ----------------------------------------------------------------------------
module hkpo_cell #(
    parameter int IW      = 4,
    parameter int CELL_ID = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hkpo_pkg::req_t            req,
    input  logic [hkpo_pkg::WORD_W-1:0] age,
    input  hkpo_pkg::cmd_t            cmd,
    input  logic [IW-1:0]             cmd_idx,
    input  hkpo_pkg::acc_t            acc_in,
    input  logic [IW-1:0]             hit_idx_in,
    input  logic [IW-1:0]             free_idx_in,
    input  logic [IW-1:0]             old_idx_in,
    output hkpo_pkg::acc_t            acc_out,
    output logic [IW-1:0]             hit_idx_out,
    output logic [IW-1:0]             free_idx_out,
    output logic [IW-1:0]             old_idx_out
);
    import hkpo_pkg::*;

    localparam logic [IW-1:0] ME = IW'(CELL_ID);

    logic              valid_reg;
    req_t              ent_reg;
    logic [WORD_W-1:0] age_reg;
    acc_t              acc_reg, acc_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [IW-1:0]     old_idx_reg, old_idx_next;
    logic              sel;

    assign sel = (cmd_idx == ME);

    always_comb
    begin
        acc_next      = acc_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        old_idx_next  = old_idx_in;
        if (!acc_in.hit && valid_reg && ent_reg.key == req.key)
        begin
            acc_next.hit = 1'b1;
            hit_idx_next = ME;
        end
        if (!acc_in.free && !valid_reg)
        begin
            acc_next.free = 1'b1;
            free_idx_next = ME;
        end
        if (valid_reg && (!acc_in.old_ok || age_reg < acc_in.old_age))
        begin
            acc_next.old_ok  = 1'b1;
            acc_next.old_age = age_reg;
            old_idx_next     = ME;
        end
        if (valid_reg && ent_reg.height == req.height && ent_reg.parent == req.parent
            && (!acc_in.ch_ok || age_reg < acc_in.ch_age))
        begin
            acc_next.ch_ok  = 1'b1;
            acc_next.ch_age = age_reg;
            acc_next.ch_key = ent_reg.key;
            acc_next.ch_tip = ent_reg.tip;
        end
        acc_next.cnt = acc_in.cnt + CNT_W'(valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && cmd.wr)
        begin
            valid_reg <= 1'b1;
        end
        else if (sel && cmd.clr)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && cmd.wr)
        begin
            ent_reg <= req;
            age_reg <= age;
        end
        acc_reg      <= acc_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        old_idx_reg  <= old_idx_next;
    end

    assign acc_out      = acc_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;
    assign old_idx_out  = old_idx_reg;

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the hash keyed pool against a behavioral pool of its own: directed
// beats for each operation and corner case, random traffic drawn mostly from
// a small set of keys and parents so that hits, duplicates, evictions and child
// matches are frequent, and a burst of inserts while output ready is held low.
// ----------------------------------------------------------------------------
module testbench;

    import hkpo_pkg::*;

    localparam int DEPTH   = 16;
    localparam int LIMIT   = 400000;

    typedef struct packed {
        logic [2:0]   status;
        logic         evicted;
        logic [255:0] match;
        logic [63:0]  tip;
        logic [4:0]   occ;
    } res_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    logic         pool_valid [DEPTH];
    logic [255:0] pool_key [DEPTH];
    logic [255:0] pool_parent [DEPTH];
    logic [63:0]  pool_height [DEPTH];
    logic [63:0]  pool_tip [DEPTH];
    logic [63:0]  pool_age [DEPTH];
    logic [63:0]  age_next;

    res_t pending_results [$];
    int   errors;
    int   cycles;
    int   hold_off;
    int   hold_req;
    int   hold_seen;
    logic [255:0] key_set [8];
    logic [255:0] par_set [4];

    hash_keyed_pool_oldest_eviction #(.POOL_DEPTH(DEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 clk = ~clk;

    function automatic int pool_count();
        int n;
        n = 0;
        for (int s = 0; s < DEPTH; s++)
            if (pool_valid[s]) n++;
        return n;
    endfunction

    function automatic int pool_lookup(logic [255:0] k);
        for (int s = 0; s < DEPTH; s++)
            if (pool_valid[s] && pool_key[s] == k) return s;
        return DEPTH;
    endfunction

    function automatic res_t pool_apply(op_t op, logic [255:0] k, logic [255:0] p,
                                        logic [63:0] h, logic [63:0] t);
        res_t r;
        int s;
        int best;
        r = '0;
        r.status = ST_NONE;
        if (op == OP_INSERT)
        begin
            if (pool_lookup(k) < DEPTH) r.status = ST_DUP;
            else
            begin
                if (pool_count() >= DEPTH)
                begin
                    best = DEPTH;
                    for (s = 0; s < DEPTH; s++)
                        if (pool_valid[s] && (best == DEPTH || pool_age[s] < pool_age[best]))
                            best = s;
                    pool_valid[best] = 1'b0;
                    r.evicted = 1'b1;
                end
                for (s = 0; s < DEPTH; s++)
                    if (!pool_valid[s]) break;
                pool_key[s] = k;
                pool_parent[s] = p;
                pool_height[s] = h;
                pool_tip[s] = t;
                pool_age[s] = age_next;
                pool_valid[s] = 1'b1;
                age_next++;
                r.status = ST_INSERTED;
            end
        end
        else if (op == OP_CONTAINS)
        begin
            r.status = (pool_lookup(k) < DEPTH) ? ST_FOUND : ST_NONE;
        end
        else if (op == OP_CHILD)
        begin
            best = DEPTH;
            for (s = 0; s < DEPTH; s++)
                if (pool_valid[s] && pool_height[s] == h && pool_parent[s] == p &&
                    (best == DEPTH || pool_age[s] < pool_age[best]))
                    best = s;
            if (best < DEPTH)
            begin
                r.status = ST_FOUND;
                r.match = pool_key[best];
                r.tip = pool_tip[best];
            end
        end
        else
        begin
            s = pool_lookup(k);
            if (s < DEPTH)
            begin
                pool_valid[s] = 1'b0;
                r.status = ST_REMOVED;
            end
        end
        r.occ = 5'(pool_count());
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [255:0] got, logic [255:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic send_beat(op_t op, logic [255:0] k, logic [255:0] p,
                             logic [63:0] h, logic [63:0] t, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, t, h, p, k, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(pool_apply(op, k, p, h, t));
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [255:0] rand_wide();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom};
    endfunction

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_off <= 400;
            m_tready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 29) == 0) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '0;
            got.status = m_tdata[2:0];
            got.evicted = m_tdata[3];
            got.match = m_tdata[259:4];
            got.tip = m_tdata[323:260];
            got.occ = m_tdata[328:324];
            if (pending_results.size() == 0) report_mismatch("unexpected beat", '0, '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 256'(got.status), 256'(want.status));
                if (got.evicted != want.evicted)
                    report_mismatch("evicted", 256'(got.evicted), 256'(want.evicted));
                if (got.match != want.match)
                    report_mismatch("match", got.match, want.match);
                if (got.tip != want.tip)
                    report_mismatch("match_seen_tip", 256'(got.tip), 256'(want.tip));
                if (got.occ != want.occ)
                    report_mismatch("occupancy", 256'(got.occ), 256'(want.occ));
            end
        end
    end

    task automatic test_directed();
        logic [255:0] ones;
        ones = '1;
        send_beat(OP_CONTAINS, ones, '0, '0, '0, 0);
        send_beat(OP_REMOVE, ones, '0, '0, '0, 0);
        send_beat(OP_CHILD, '0, '0, '0, '0, 0);
        send_beat(OP_INSERT, ones, ones, '1, '1, 0);
        send_beat(OP_INSERT, ones, '0, '0, '0, 0);
        send_beat(OP_INSERT, '0, ones, '1, 64'd5, 1);
        send_beat(OP_CHILD, '0, ones, '1, '0, 0);
        send_beat(OP_CONTAINS, '0, '0, '0, '0, 2);
        send_beat(OP_REMOVE, ones, '0, '0, '0, 0);
        send_beat(OP_CONTAINS, ones, '0, '0, '0, 0);
        send_beat(OP_CHILD, '0, ones, 64'd3, '0, 0);
        for (int i = 0; i < 18; i++)
            send_beat(OP_INSERT, 256'(i + 100), ones, '1, 64'(i), 0);
        send_beat(OP_CHILD, '0, ones, '1, '0, 0);
        send_beat(OP_REMOVE, 256'd105, '0, '0, '0, 0);
        wait_drain();
    endtask

    task automatic test_random(int count);
        int pick;
        op_t op;
        logic [255:0] k;
        logic [255:0] p;
        logic [63:0] h;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            op = op_t'($urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0) op = OP_INSERT;
            k = (pick < 8) ? key_set[$urandom_range(0, 7)] : rand_wide();
            if ($urandom_range(0, 3) == 0) k = 256'($urandom_range(0, 40));
            p = (pick < 9) ? par_set[$urandom_range(0, 3)] : rand_wide();
            h = (pick < 8) ? 64'($urandom_range(0, 2)) : {$urandom, $urandom};
            send_beat(op, k, p, h, {$urandom, $urandom}, rand_gap());
        end
    endtask

    task automatic test_backpressure();
        hold_req <= hold_req + 1;
        for (int i = 0; i < 12; i++)
            send_beat(OP_INSERT, rand_wide(), par_set[0], '0, {$urandom, $urandom}, 0);
        wait_drain();
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        age_next = 0;
        for (int s = 0; s < DEPTH; s++) pool_valid[s] = 1'b0;
        for (int i = 0; i < 8; i++) key_set[i] = rand_wide();
        for (int i = 0; i < 4; i++) par_set[i] = rand_wide();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(550);
        test_backpressure();
        test_random(550);
        wait_drain();
        repeat (3 * (DEPTH + 2)) @(posedge clk);
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
